@@ hw/rtl/overwriting_record_ring_buffer_macros.svh @@
// Assertion macros used by the record ring buffer RTL.
`ifndef OVERWRITING_RECORD_RING_BUFFER_MACROS_SVH
`define OVERWRITING_RECORD_RING_BUFFER_MACROS_SVH

// same-cycle implication
`define ORRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("orrb assertion failed");

// next-cycle implication
`define ORRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("orrb assertion failed");

`endif

@@ hw/rtl/orrb_pkg.sv @@
// Types and constants of the record ring buffer.
package orrb_pkg;

  localparam int QDEPTH = 64;
  localparam int QAW    = 6;
  localparam int PTR_W  = 6;
  localparam int LEN_W  = 7;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PTR_W-1:0] start;
  } desc_t;

endpackage

@@ hw/rtl/overwriting_record_ring_buffer.sv @@
// Top level: overwriting record ring buffer with a descriptor queue.
//
// Usage:
//   Command channel: drive req_type, data_byte, end_of_record and pulse start
//   while busy is low; the word is taken at that clock edge.
//   Result channel: each result word is on status, read_byte and last_of_run
//   for one cycle with strobe high. The receiver cannot stall.
//   Write byte: one result, after every oldest record that the byte overwrites
//   is dropped (one descriptor RAM read each).
//   The result strobe comes in the cycle after the item's last busy cycle.
//   Read: fetches the oldest descriptor, then streams its bytes out of the
//   ring RAM at one byte per cycle; each byte appears in the cycle after
//   its ring RAM address is presented.
//   Empty read: one result with the empty status.
//   A byte beyond BUF_BYTES in one record is refused with the too-long status.
//   Reset (rst, synchronous) empties the queue and zeroes the pointers; the
//   RAMs are not cleared and need no clearing pass.
`include "overwriting_record_ring_buffer_macros.svh"

module overwriting_record_ring_buffer #(
  parameter int BUF_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic       end_of_record,
  output logic       strobe,
  output logic [1:0] status,
  output logic [7:0] read_byte,
  output logic       last_of_run
);

  localparam int RAW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int LW  = orrb_pkg::LEN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRD   = 3'd1;
  localparam logic [2:0] S_WCHK  = 3'd2;
  localparam logic [2:0] S_RDESC = 3'd3;
  localparam logic [2:0] S_RRUN  = 3'd4;

  logic [2:0]  state;
  logic        req_q;
  logic [7:0]  byte_q;
  logic        eor_q;

  logic [orrb_pkg::QAW-1:0] head;
  logic [LW-1:0]            count;
  logic [RAW-1:0]           wp;
  logic [RAW-1:0]           open_start;
  logic [LW-1:0]            open_len;
  logic [RAW-1:0]           cur;
  logic [LW-1:0]            rem;

  logic       strobe_q;
  logic [1:0] status_q;
  logic       last_q;
  logic       ring_sel_q;

  orrb_pkg::desc_t q_rdata;
  orrb_pkg::desc_t q_wdata;
  logic            q_we;
  logic [orrb_pkg::QAW-1:0] q_waddr;
  logic [7:0]      ring_rdata;
  logic            ring_we;

  logic [RAW-1:0] d_start;
  logic [RAW:0]   off;
  logic           holds;
  logic           too_long;
  logic           drop_now;
  logic           commit;
  logic [LW-1:0]  d_len_clamped;
  logic [RAW-1:0] wp_inc;
  logic [RAW-1:0] cur_inc;

  orrb_ram #(.WIDTH($bits(orrb_pkg::desc_t)), .DEPTH(orrb_pkg::QDEPTH)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head),
    .rdata (q_rdata)
  );

  orrb_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp),
    .wdata (byte_q),
    .raddr (cur),
    .rdata (ring_rdata)
  );

  always_comb begin
    d_start = q_rdata.start[RAW-1:0];
    off = {1'b0, wp} - {1'b0, d_start};
    if (wp < d_start) begin
      off = off + (RAW+1)'(BUF_BYTES);
    end
    holds    = LW'(off) < q_rdata.len;
    too_long = open_len >= LW'(BUF_BYTES);
    drop_now = !too_long && (count != '0) && holds;
    commit   = (state == S_WCHK) && !drop_now && eor_q;
    ring_we  = (state == S_WCHK) && !drop_now && !too_long;
    q_we     = commit;
    q_waddr  = head + count[orrb_pkg::QAW-1:0];
    q_wdata.len   = too_long ? open_len : open_len + LW'(1);
    q_wdata.start = orrb_pkg::PTR_W'((!too_long && open_len == '0) ? wp : open_start);
    d_len_clamped = (q_rdata.len > LW'(BUF_BYTES)) ? LW'(BUF_BYTES) : q_rdata.len;
    wp_inc  = (wp == RAW'(BUF_BYTES - 1)) ? '0 : wp + RAW'(1);
    cur_inc = (cur == RAW'(BUF_BYTES - 1)) ? '0 : cur + RAW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      wp         <= '0;
      open_start <= '0;
      open_len   <= '0;
      strobe_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q  <= req_type;
            byte_q <= data_byte;
            eor_q  <= end_of_record;
            state  <= (req_type == orrb_pkg::REQ_READ) ? S_RDESC : S_WCHK;
          end
        end
        S_WRD: begin
          state <= S_WCHK;
        end
        S_WCHK: begin
          if (drop_now) begin
            head  <= head + orrb_pkg::QAW'(1);
            count <= count - LW'(1);
            state <= S_WRD;
          end else begin
            if (!too_long) begin
              if (open_len == '0) begin
                open_start <= wp;
              end
              wp <= wp_inc;
            end
            if (commit) begin
              open_len <= '0;
              if (count[LW-1]) begin
                head <= head + orrb_pkg::QAW'(1);
              end else begin
                count <= count + LW'(1);
              end
            end else if (!too_long) begin
              open_len <= open_len + LW'(1);
            end
            strobe_q   <= 1'b1;
            status_q   <= too_long ? orrb_pkg::ST_TOO_LONG : orrb_pkg::ST_OK;
            last_q     <= 1'b1;
            ring_sel_q <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_RDESC: begin
          if (count == '0) begin
            strobe_q   <= 1'b1;
            status_q   <= orrb_pkg::ST_EMPTY;
            last_q     <= 1'b1;
            ring_sel_q <= 1'b0;
            state      <= S_IDLE;
          end else begin
            head  <= head + orrb_pkg::QAW'(1);
            count <= count - LW'(1);
            if (d_len_clamped == '0) begin
              strobe_q   <= 1'b1;
              status_q   <= orrb_pkg::ST_OK;
              last_q     <= 1'b1;
              ring_sel_q <= 1'b0;
              state      <= S_IDLE;
            end else begin
              cur   <= d_start;
              rem   <= d_len_clamped;
              state <= S_RRUN;
            end
          end
        end
        S_RRUN: begin
          strobe_q   <= 1'b1;
          status_q   <= orrb_pkg::ST_OK;
          last_q     <= (rem == LW'(1));
          ring_sel_q <= 1'b1;
          cur        <= cur_inc;
          rem        <= rem - LW'(1);
          if (rem == LW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state != S_IDLE);
  assign strobe      = strobe_q;
  assign status      = status_q;
  assign last_of_run = last_q;
  assign read_byte   = ring_sel_q ? ring_rdata : 8'd0;

  // an accepted word always keeps the block busy in the next cycle
  `ORRB_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // ring bytes only come out with ok status
  `ORRB_ASSERT_NOW(a_ring_ok, clk, rst, strobe && ring_sel_q, status == orrb_pkg::ST_OK)
  // open record never grows past the ring
  `ORRB_ASSERT_NOW(a_open_len, clk, rst, 1'b1, open_len <= LW'(BUF_BYTES))
  // a read in progress always has bytes left
  `ORRB_ASSERT_NOW(a_run_rem, clk, rst, state == S_RRUN, rem != '0)
  // a write item never issues a read run
  `ORRB_ASSERT_NOW(a_write_path, clk, rst,
    state == S_WCHK || state == S_WRD, req_q == orrb_pkg::REQ_WRITE)

endmodule

@@ hw/rtl/orrb_ram.sv @@
// Generic simple dual-port RAM with registered read.
module orrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
